FILE: hw/rtl/deadline_batch_request_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Deadline batch request scheduler - assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_BATCH_REQUEST_SCHEDULER_MACROS_SVH
`define DEADLINE_BATCH_REQUEST_SCHEDULER_MACROS_SVH

// same-cycle implication
`define DBRS_ASSERT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DBRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/dbrs_pkg.sv
// ----------------------------------------------------------------------------
// dbrs_pkg
// Shared widths, register indexes, class codes and word types.
// ----------------------------------------------------------------------------
package dbrs_pkg;

	localparam int NCLASS              = 4;
	localparam int CLS_W               = 2;
	localparam int TAG_BITS            = 8;
	localparam int TIME_W              = 32;
	localparam int EXP_W               = 16;
	localparam int LIM_W               = 8;
	localparam int CFG_W               = 16;
	localparam int CFG_IDX_W           = 3;
	localparam int DEFAULT_QUEUE_DEPTH = 16;

	// tick rate
	localparam int HZ = 100;

	localparam logic [EXP_W-1:0] SYNC_EXP_RST    = EXP_W'(1 * HZ);
	localparam logic [EXP_W-1:0] ASYNC_EXP_RST   = EXP_W'(2 * HZ);
	localparam logic [LIM_W-1:0] BATCH_LIMIT_RST = LIM_W'(1);
	localparam logic [LIM_W-1:0] STARVE_LIMIT_RST = LIM_W'(1);
	localparam logic [LIM_W-1:0] CNT_MAX         = '1;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_RD_EXP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WR_EXP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ASYNC_RD_EXP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ASYNC_WR_EXP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STARVE_LIMIT = 3'd5;

	localparam logic FUNC_ADD      = 1'b0;
	localparam logic FUNC_DISPATCH = 1'b1;

	// class code: {sync, write}
	localparam logic [CLS_W-1:0] CLS_ASYNC_RD = 2'd0;
	localparam logic [CLS_W-1:0] CLS_ASYNC_WR = 2'd1;
	localparam logic [CLS_W-1:0] CLS_SYNC_RD  = 2'd2;
	localparam logic [CLS_W-1:0] CLS_SYNC_WR  = 2'd3;

	typedef struct packed {
		logic                func;
		logic [TAG_BITS-1:0] request_tag;
		logic                is_sync;
		logic                is_write;
		logic [TIME_W-1:0]   current_time;
	} req_word_t;

	typedef struct packed {
		logic                dispatch_valid;
		logic [TAG_BITS-1:0] out_tag;
		logic                out_sync;
		logic                out_write;
		logic                out_expired;
		logic                add_dropped;
	} rsp_word_t;

	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic [TIME_W-1:0]   deadline;
	} entry_t;

	typedef struct packed {
		logic             valid;
		logic [CLS_W-1:0] cls;
		entry_t           entry;
	} push_t;

	typedef struct packed {
		logic             valid;
		logic [CLS_W-1:0] cls;
	} pop_t;

	typedef struct packed {
		logic             en;
		logic [CLS_W-1:0] cls;
	} rdreq_t;

	typedef struct packed {
		logic [NCLASS-1:0] nonempty;
		logic [NCLASS-1:0] full;
	} qstat_t;

endpackage

FILE: hw/rtl/dbrs_req_if.sv
// ----------------------------------------------------------------------------
// dbrs_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface dbrs_req_if import dbrs_pkg::*;;
	logic      valid;
	logic      ready;
	req_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/dbrs_rsp_if.sv
// ----------------------------------------------------------------------------
// dbrs_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface dbrs_rsp_if import dbrs_pkg::*;;
	logic      valid;
	logic      ready;
	rsp_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/dbrs_qstore.sv
// ----------------------------------------------------------------------------
// dbrs_qstore
// Four circular request FIFOs sharing one entry memory; head and fill
// pointers per class, one push, one pop and one registered head read.
// ----------------------------------------------------------------------------
module dbrs_qstore import dbrs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  pop_t   pop,
	input  rdreq_t rdreq,
	output qstat_t stat,
	output entry_t rd_entry
);

	localparam int PW        = $clog2(QUEUE_DEPTH);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int SW        = PW + 1;
	localparam int MEM_DEPTH = NCLASS * (1 << PW);

	logic [PW-1:0] head_q [NCLASS];
	logic [CW-1:0] count_q [NCLASS];
	entry_t        mem_q [MEM_DEPTH];
	entry_t        rd_entry_q;

	logic [SW-1:0]       tail_sum;
	logic [PW-1:0]       tail;
	logic [CLS_W+PW-1:0] wr_addr;
	logic [CLS_W+PW-1:0] rd_addr;

	always_comb begin
		tail_sum = SW'(head_q[push.cls]) + SW'(count_q[push.cls]);
		if (tail_sum >= SW'(QUEUE_DEPTH)) begin
			tail = PW'(tail_sum - SW'(QUEUE_DEPTH));
		end else begin
			tail = PW'(tail_sum);
		end
		wr_addr = {push.cls, tail};
		rd_addr = {rdreq.cls, head_q[rdreq.cls]};
	end

	always_comb begin
		for (int c = 0; c < NCLASS; c++) begin
			stat.nonempty[c] = (count_q[c] != '0);
			stat.full[c]     = (count_q[c] == CW'(QUEUE_DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCLASS; c++) begin
				head_q[c]  <= '0;
				count_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < NCLASS; c++) begin
				if (push.valid && push.cls == CLS_W'(c)) begin
					count_q[c] <= count_q[c] + CW'(1);
				end else if (pop.valid && pop.cls == CLS_W'(c)) begin
					count_q[c] <= count_q[c] - CW'(1);
					if (head_q[c] == PW'(QUEUE_DEPTH - 1)) begin
						head_q[c] <= '0;
					end else begin
						head_q[c] <= head_q[c] + PW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_addr] <= push.entry;
		end
		if (rdreq.en) begin
			rd_entry_q <= mem_q[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;

endmodule

FILE: hw/rtl/deadline_batch_request_scheduler.sv
// ----------------------------------------------------------------------------
// deadline_batch_request_scheduler
// Four deadline-stamped request FIFOs (sync/async x read/write) with batched
// expiry check and read-preferring dispatch under a write starvation limit.
// ----------------------------------------------------------------------------
//  channel  dir  word        handshake
//  req      in   req_word_t  valid & ready
//  rsp      out  rsp_word_t  valid & ready
//  cfg      in   16b data    cfg_we, no back-pressure
//
//  Add: entry write, then result register.
//  Dispatch: head read, then pop and result register; the expiry check,
//  when it runs, reads each nonempty head in turn, bound by the single
//  memory read port. One request in work at a time; a stalled result
//  holds the next request in its pop or emit state. Reset empties all FIFOs
//  and loads the register defaults; entries are not cleared.
// ----------------------------------------------------------------------------
module deadline_batch_request_scheduler import dbrs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dbrs_req_if.sink             req,
	dbrs_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_POP   = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic             hit;
		logic [CLS_W-1:0] val;
	} pick_t;

	state_t state_q, state_d;

	logic [EXP_W-1:0] srd_exp_q, swr_exp_q, ard_exp_q, awr_exp_q;
	logic [LIM_W-1:0] batch_limit_q, starve_limit_q;
	logic [LIM_W-1:0] batch_q, streak_q;

	logic [TIME_W-1:0] now_q;
	logic [CLS_W-1:0]  pos_q, pos_d;
	logic [CLS_W-1:0]  cls_q, cls_d;
	logic              exp_q, exp_d;
	logic              drop_q, drop_d;

	logic      rsp_valid_q;
	rsp_word_t rsp_word_q, rsp_word_d;

	qstat_t stat;
	entry_t rd_entry;
	push_t  push;
	pop_t   pop;
	rdreq_t rdreq;

	logic              in_fire, out_free, rsp_load, batch_clr, expired, dir;
	logic [TIME_W-1:0] slack;
	logic [2:0]        exp_lo;
	logic [CLS_W-1:0]  add_cls;
	pick_t             exp_pick, norm_pick;

	// expiry scan order: async write, async read, sync write, sync read
	function automatic logic [CLS_W-1:0] pos2cls(input logic [CLS_W-1:0] pos);
		return {pos[1], ~pos[0]};
	endfunction

	function automatic pick_t find_expiry(input logic [NCLASS-1:0] nonempty,
			input logic [2:0] lo);
		pick_t p;
		p = '0;
		for (int i = NCLASS - 1; i >= 0; i--) begin
			if (3'(i) >= lo && nonempty[pos2cls(CLS_W'(i))]) begin
				p.hit = 1'b1;
				p.val = CLS_W'(i);
			end
		end
		return p;
	endfunction

	// sync before async; reads first unless dir
	function automatic pick_t find_normal(input logic [NCLASS-1:0] nonempty,
			input logic dir_w);
		pick_t            p;
		logic [CLS_W-1:0] c;
		p = '0;
		for (int i = NCLASS - 1; i >= 0; i--) begin
			c = {~i[1], i[0] ^ dir_w};
			if (nonempty[c]) begin
				p.hit = 1'b1;
				p.val = c;
			end
		end
		return p;
	endfunction

	function automatic logic [EXP_W-1:0] class_expiry(input logic [CLS_W-1:0] c,
			input logic [EXP_W-1:0] ard, input logic [EXP_W-1:0] awr,
			input logic [EXP_W-1:0] srd, input logic [EXP_W-1:0] swr);
		logic [EXP_W-1:0] e;
		unique case (c)
			CLS_ASYNC_RD: e = ard;
			CLS_ASYNC_WR: e = awr;
			CLS_SYNC_RD:  e = srd;
			default:      e = swr;
		endcase
		return e;
	endfunction

	dbrs_qstore #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_qstore (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.rdreq    (rdreq),
		.stat     (stat),
		.rd_entry (rd_entry)
	);

	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_word_q;

	always_comb begin
		in_fire   = req.valid && req.ready;
		out_free  = !rsp_valid_q || rsp.ready;
		dir       = (streak_q > starve_limit_q);
		slack     = rd_entry.deadline - now_q;
		expired   = slack[TIME_W-1];
		exp_lo    = (state_q == ST_CHECK) ? ({1'b0, pos_q} + 3'd1) : 3'd0;
		exp_pick  = find_expiry(stat.nonempty, exp_lo);
		norm_pick = find_normal(stat.nonempty, dir);
		add_cls   = {req.payload.is_sync, req.payload.is_write};

		state_d   = state_q;
		pos_d     = pos_q;
		cls_d     = cls_q;
		exp_d     = exp_q;
		drop_d    = drop_q;
		batch_clr = 1'b0;
		push      = '0;
		pop       = '0;
		rdreq     = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (req.payload.func == FUNC_ADD) begin
						drop_d               = stat.full[add_cls];
						push.valid           = !stat.full[add_cls];
						push.cls             = add_cls;
						push.entry.tag       = req.payload.request_tag;
						push.entry.deadline  = req.payload.current_time + TIME_W'(
							class_expiry(add_cls, ard_exp_q, awr_exp_q, srd_exp_q, swr_exp_q));
						state_d              = ST_EMIT;
					end else begin
						drop_d = 1'b0;
						priority if (batch_q > batch_limit_q) begin
							batch_clr = 1'b1;
							if (exp_pick.hit) begin
								rdreq.en  = 1'b1;
								rdreq.cls = pos2cls(exp_pick.val);
								pos_d     = exp_pick.val;
								state_d   = ST_CHECK;
							end else begin
								state_d = ST_EMIT;
							end
						end else if (norm_pick.hit) begin
							rdreq.en  = 1'b1;
							rdreq.cls = norm_pick.val;
							cls_d     = norm_pick.val;
							exp_d     = 1'b0;
							state_d   = ST_POP;
						end else begin
							state_d = ST_EMIT;
						end
					end
				end
			end
			ST_CHECK: begin
				priority if (expired) begin
					cls_d   = pos2cls(pos_q);
					exp_d   = 1'b1;
					state_d = ST_POP;
				end else if (exp_pick.hit) begin
					rdreq.en  = 1'b1;
					rdreq.cls = pos2cls(exp_pick.val);
					pos_d     = exp_pick.val;
				end else if (norm_pick.hit) begin
					rdreq.en  = 1'b1;
					rdreq.cls = norm_pick.val;
					cls_d     = norm_pick.val;
					exp_d     = 1'b0;
					state_d   = ST_POP;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_POP: begin
				if (out_free) begin
					pop.valid = 1'b1;
					pop.cls   = cls_q;
					state_d   = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_load   = ((state_q == ST_POP) || (state_q == ST_EMIT)) && out_free;
		rsp_word_d = '0;
		if (state_q == ST_POP) begin
			rsp_word_d.dispatch_valid = 1'b1;
			rsp_word_d.out_tag        = rd_entry.tag;
			rsp_word_d.out_sync       = cls_q[1];
			rsp_word_d.out_write      = cls_q[0];
			rsp_word_d.out_expired    = exp_q;
		end else begin
			rsp_word_d.add_dropped = drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			batch_q     <= '0;
			streak_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (batch_clr) begin
				batch_q <= '0;
			end else if (pop.valid && batch_q != CNT_MAX) begin
				batch_q <= batch_q + LIM_W'(1);
			end
			if (pop.valid) begin
				if (pop.cls[0]) begin
					streak_q <= '0;
				end else if (streak_q != CNT_MAX) begin
					streak_q <= streak_q + LIM_W'(1);
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q <= req.payload.current_time;
		end
		pos_q  <= pos_d;
		cls_q  <= cls_d;
		exp_q  <= exp_d;
		drop_q <= drop_d;
		if (rsp_load) begin
			rsp_word_q <= rsp_word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srd_exp_q      <= SYNC_EXP_RST;
			swr_exp_q      <= SYNC_EXP_RST;
			ard_exp_q      <= ASYNC_EXP_RST;
			awr_exp_q      <= ASYNC_EXP_RST;
			batch_limit_q  <= BATCH_LIMIT_RST;
			starve_limit_q <= STARVE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SYNC_RD_EXP:  srd_exp_q      <= cfg_data[EXP_W-1:0];
				REG_SYNC_WR_EXP:  swr_exp_q      <= cfg_data[EXP_W-1:0];
				REG_ASYNC_RD_EXP: ard_exp_q      <= cfg_data[EXP_W-1:0];
				REG_ASYNC_WR_EXP: awr_exp_q      <= cfg_data[EXP_W-1:0];
				REG_BATCH_LIMIT:  batch_limit_q  <= cfg_data[LIM_W-1:0];
				REG_STARVE_LIMIT: starve_limit_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/dbrs_checker.sv
// ----------------------------------------------------------------------------
// dbrs_checker
// Port-level checks on the scheduler's request and result channels.
// ----------------------------------------------------------------------------
`include "deadline_batch_request_scheduler_macros.svh"

module dbrs_checker import dbrs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_word_t rsp_word
);

	`DBRS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled result word changed")
	`DBRS_ASSERT(a_one_kind, clk, arst_n, rsp_valid, !(rsp_word.dispatch_valid && rsp_word.add_dropped), "result both dispatched and dropped")
	`DBRS_ASSERT(a_empty_zero, clk, arst_n, rsp_valid && !rsp_word.dispatch_valid, rsp_word.out_tag == '0 && !rsp_word.out_sync && !rsp_word.out_write && !rsp_word.out_expired, "non-dispatch result carries request fields")
	`DBRS_ASSERT_NEXT(a_single_word, clk, arst_n, req_valid && req_ready, !req_ready, "request word taken while previous one in work")

endmodule

bind deadline_batch_request_scheduler dbrs_checker u_dbrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_word  (rsp.payload)
);
